/* sv/priority_timeout_command_mux_top_macros.svh */
// ----------------------------------------------------------------------------
// priority_timeout_command_mux_top_macros
// assertion macros shared by the checker of the priority command mux
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TIMEOUT_COMMAND_MUX_TOP_MACROS_SVH
`define PRIORITY_TIMEOUT_COMMAND_MUX_TOP_MACROS_SVH

// same-cycle implication on clk, off during rst
`define PTCM_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication on clk, off during rst
`define PTCM_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* sv/ptcm_pkg.sv */
// ----------------------------------------------------------------------------
// ptcm_pkg
// types and codes of the priority command mux
// ----------------------------------------------------------------------------
package ptcm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [1:0] OP_MSG   = 2'd0;
  localparam logic [1:0] OP_SUB   = 2'd1;
  localparam logic [1:0] OP_UNSUB = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] RC_ACCEPTED   = 3'd0;
  localparam logic [2:0] RC_SRC_DUP    = 3'd1;
  localparam logic [2:0] RC_PRIO_USED  = 3'd2;
  localparam logic [2:0] RC_NOT_FOUND  = 3'd3;
  localparam logic [2:0] RC_FORWARDED  = 3'd4;
  localparam logic [2:0] RC_SUPPRESSED = 3'd5;
  localparam logic [2:0] RC_EMPTY      = 3'd6;

  typedef struct packed {
    logic match;
    logic active;
  } cmp_res_t;

endpackage

/* sv/priority_timeout_command_mux_top.sv */
// the slot scan reads one table entry per cycle through the single memory read
//   port and the shared compare unit; a message on an empty or out-of-range slot
//   skips the scan, and no new command is taken until the result word is loaded
// reset: clears all slot valid flags at once, no clearing pass
// ----------------------------------------------------------------------------
// priority_timeout_command_mux_top
// priority command mux with per-source activity timeout
// ----------------------------------------------------------------------------
module priority_timeout_command_mux_top #(
  parameter int PRIORITY_LEVELS = 16,
  parameter int TIME_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  prio_level,
  input  logic [7:0]  source_id,
  input  logic [31:0] timeout_ticks,
  input  logic [31:0] now_time,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  result_code,
  output logic        forward
);
  import ptcm_pkg::*;

  localparam int IDX_W = $clog2(PRIORITY_LEVELS);

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [7:0]           rd_src;
  logic [TIME_BITS-1:0] rd_tmo;
  logic [TIME_BITS-1:0] rd_last;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_src_en;
  logic                 wr_tmo_en;
  logic                 wr_last_en;
  logic [7:0]           wr_src;
  logic [TIME_BITS-1:0] wr_tmo;
  logic [TIME_BITS-1:0] wr_last;
  logic [7:0]           item_src;
  logic [TIME_BITS-1:0] item_now;
  cmp_res_t             cmp_res;

  ptcm_seq #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .TIME_BITS      (TIME_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .op           (op),
    .prio_level   (prio_level),
    .source_id    (source_id),
    .timeout_ticks(timeout_ticks),
    .now_time     (now_time),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_code  (result_code),
    .forward      (forward),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_src_en    (wr_src_en),
    .wr_tmo_en    (wr_tmo_en),
    .wr_last_en   (wr_last_en),
    .wr_src       (wr_src),
    .wr_tmo       (wr_tmo),
    .wr_last      (wr_last),
    .item_src     (item_src),
    .item_now     (item_now),
    .cmp_res      (cmp_res)
  );

  ptcm_slot_mem #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .TIME_BITS      (TIME_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_src    (rd_src),
    .rd_tmo    (rd_tmo),
    .rd_last   (rd_last),
    .wr_addr   (wr_addr),
    .wr_src_en (wr_src_en),
    .wr_tmo_en (wr_tmo_en),
    .wr_last_en(wr_last_en),
    .wr_src    (wr_src),
    .wr_tmo    (wr_tmo),
    .wr_last   (wr_last)
  );

  ptcm_cmp #(
    .TIME_BITS(TIME_BITS)
  ) u_cmp (
    .item_src (item_src),
    .item_now (item_now),
    .slot_src (rd_src),
    .slot_tmo (rd_tmo),
    .slot_last(rd_last),
    .res      (cmp_res)
  );

endmodule

/* sv/ptcm_cmp.sv */
// ----------------------------------------------------------------------------
// ptcm_cmp
// shared slot compare unit: source id match and wrapping activity test
// ----------------------------------------------------------------------------
module ptcm_cmp #(
  parameter int TIME_BITS = 32
) (
  input  logic [7:0]           item_src,
  input  logic [TIME_BITS-1:0] item_now,
  input  logic [7:0]           slot_src,
  input  logic [TIME_BITS-1:0] slot_tmo,
  input  logic [TIME_BITS-1:0] slot_last,
  output ptcm_pkg::cmp_res_t   res
);
  import ptcm_pkg::*;

  logic [TIME_BITS-1:0] age;

  always_comb begin
    age        = item_now - slot_last;
    res.match  = (item_src == slot_src);
    res.active = (age < slot_tmo);
  end

endmodule

/* sv/ptcm_slot_mem.sv */
// ----------------------------------------------------------------------------
// ptcm_slot_mem
// slot table memories: source id, timeout and last message time
// ----------------------------------------------------------------------------
module ptcm_slot_mem #(
  parameter int PRIORITY_LEVELS = 16,
  parameter int TIME_BITS       = 32,
  localparam int IDX_W          = $clog2(PRIORITY_LEVELS)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [7:0]           rd_src,
  output logic [TIME_BITS-1:0] rd_tmo,
  output logic [TIME_BITS-1:0] rd_last,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic                 wr_src_en,
  input  logic                 wr_tmo_en,
  input  logic                 wr_last_en,
  input  logic [7:0]           wr_src,
  input  logic [TIME_BITS-1:0] wr_tmo,
  input  logic [TIME_BITS-1:0] wr_last
);
  import ptcm_pkg::*;

  logic [7:0]           mem_src  [PRIORITY_LEVELS];
  logic [TIME_BITS-1:0] mem_tmo  [PRIORITY_LEVELS];
  logic [TIME_BITS-1:0] mem_last [PRIORITY_LEVELS];

  always_ff @(posedge clk) begin
    if (wr_src_en) begin
      mem_src[wr_addr] <= wr_src;
    end
    if (wr_tmo_en) begin
      mem_tmo[wr_addr] <= wr_tmo;
    end
    if (wr_last_en) begin
      mem_last[wr_addr] <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_src  <= mem_src[rd_addr];
      rd_tmo  <= mem_tmo[rd_addr];
      rd_last <= mem_last[rd_addr];
    end
  end

endmodule

/* sv/ptcm_seq.sv */
// ----------------------------------------------------------------------------
// ptcm_seq
// command sequencer: slot scan, valid flags, table updates, result register
// ----------------------------------------------------------------------------
module ptcm_seq #(
  parameter int PRIORITY_LEVELS = 16,
  parameter int TIME_BITS       = 32,
  localparam int IDX_W          = $clog2(PRIORITY_LEVELS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [1:0]           op,
  input  logic [3:0]           prio_level,
  input  logic [7:0]           source_id,
  input  logic [31:0]          timeout_ticks,
  input  logic [31:0]          now_time,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [2:0]           result_code,
  output logic                 forward,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     wr_addr,
  output logic                 wr_src_en,
  output logic                 wr_tmo_en,
  output logic                 wr_last_en,
  output logic [7:0]           wr_src,
  output logic [TIME_BITS-1:0] wr_tmo,
  output logic [TIME_BITS-1:0] wr_last,
  output logic [7:0]           item_src,
  output logic [TIME_BITS-1:0] item_now,
  input  ptcm_pkg::cmp_res_t   cmp_res
);
  import ptcm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PRIORITY_LEVELS - 1);
  localparam logic [8:0]       LEVELS_9 = 9'(PRIORITY_LEVELS);

  state_t               state;
  state_t               state_next;
  logic [1:0]           op_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 in_range_q;
  logic [7:0]           src_q;
  logic [TIME_BITS-1:0] tmo_q;
  logic [TIME_BITS-1:0] now_q;
  logic [IDX_W-1:0]     idx;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [PRIORITY_LEVELS-1:0] slot_valid;

  logic [IDX_W+3:0]     prio_wide;
  logic [IDX_W-1:0]     prio_slot;
  logic                 in_range;
  logic                 accept;
  logic                 eval_hit;
  logic                 out_ready;
  logic                 out_load;
  logic                 sub_write;
  logic                 msg_write;
  logic                 unsub_clr;
  logic [2:0]           code_next;
  logic                 fwd_next;

  assign prio_wide = {{IDX_W{1'b0}}, prio_level};
  assign prio_slot = prio_wide[IDX_W-1:0];
  assign in_range  = (9'(prio_level) < LEVELS_9);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_ready = !res_valid || !res_stall;
  assign item_src  = src_q;
  assign item_now  = now_q;
  assign rd_addr   = idx;

  always_comb begin
    if (op_q == OP_MSG) begin
      eval_hit = slot_valid[rd_idx] && cmp_res.active && (rd_idx > slot_q);
    end else begin
      eval_hit = slot_valid[rd_idx] && cmp_res.match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = (state != ST_IDLE);
    rd_en      = 1'b0;
    out_load   = 1'b0;
    sub_write  = 1'b0;
    msg_write  = 1'b0;
    unsub_clr  = 1'b0;
    code_next  = RC_ACCEPTED;
    fwd_next   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (op == OP_MSG && !(in_range && slot_valid[prio_slot])) begin
            state_next = ST_FINISH;
          end else if (op != OP_NONE) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        unique case (op_q)
          OP_SUB: begin
            if (hit) begin
              code_next = RC_SRC_DUP;
            end else if (!in_range_q || slot_valid[slot_q]) begin
              code_next = RC_PRIO_USED;
            end else begin
              code_next = RC_ACCEPTED;
              sub_write = out_ready;
            end
          end
          OP_UNSUB: begin
            if (hit) begin
              code_next = RC_ACCEPTED;
              unsub_clr = out_ready;
            end else begin
              code_next = RC_NOT_FOUND;
            end
          end
          OP_MSG: begin
            if (!(in_range_q && slot_valid[slot_q])) begin
              code_next = RC_EMPTY;
            end else begin
              msg_write = out_ready;
              if (hit) begin
                code_next = RC_SUPPRESSED;
              end else begin
                code_next = RC_FORWARDED;
                fwd_next  = 1'b1;
              end
            end
          end
          default: begin
            code_next = RC_EMPTY;
          end
        endcase
        if (out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wr_addr    = slot_q;
  assign wr_src_en  = sub_write;
  assign wr_tmo_en  = sub_write;
  assign wr_last_en = sub_write || msg_write;
  assign wr_src     = src_q;
  assign wr_tmo     = tmo_q;
  assign wr_last    = sub_write ? '0 : now_q;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (accept) begin
        hit <= 1'b0;
      end else if (rd_vld && eval_hit && !hit) begin
        hit <= 1'b1;
      end
      if (sub_write) begin
        slot_valid[slot_q] <= 1'b1;
      end
      if (unsub_clr) begin
        slot_valid[hit_idx] <= 1'b0;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      slot_q     <= prio_slot;
      in_range_q <= in_range;
      src_q      <= source_id;
      tmo_q      <= TIME_BITS'(timeout_ticks);
      now_q      <= TIME_BITS'(now_time);
      idx        <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
    end
    rd_idx <= idx;
    if (rd_vld && eval_hit && !hit) begin
      hit_idx <= rd_idx;
    end
    if (out_load) begin
      result_code <= code_next;
      forward     <= fwd_next;
    end
  end

endmodule

/* sv/ptcm_check.sv */
// ----------------------------------------------------------------------------
// ptcm_check
// port-level checker of the priority command mux, bound to the top level
// ----------------------------------------------------------------------------
`include "priority_timeout_command_mux_top_macros.svh"

module ptcm_check (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input logic [1:0] op,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] result_code,
  input logic       forward
);
  import ptcm_pkg::*;

  `PTCM_ASSERT_IMP(a_fwd_code, res_valid,
    forward == (result_code == RC_FORWARDED),
    "forward flag disagrees with result code")
  `PTCM_ASSERT_IMP(a_code_range, res_valid, result_code <= RC_EMPTY,
    "result code out of range")
  `PTCM_ASSERT_NXT(a_busy_after_cmd,
    cmd_valid && !cmd_stall && (op == OP_MSG || op == OP_SUB || op == OP_UNSUB),
    cmd_stall, "mux not busy after a command word")
  `PTCM_ASSERT_NXT(a_idle_after_none, cmd_valid && !cmd_stall && op == OP_NONE,
    !cmd_stall, "unused op code left the mux busy")
  `PTCM_ASSERT_NXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(result_code) && $stable(forward),
    "stalled result word changed")

endmodule

bind priority_timeout_command_mux_top ptcm_check u_check (.*);

/* verif/priority_timeout_command_mux_top_tb.sv */
// ----------------------------------------------------------------------------
// priority_timeout_command_mux_top_tb
// self-checking bench for the priority command mux: a short table of command
// words with hand-read replies, then random subscribe, unsubscribe and message
// traffic on a wrapping tick clock, all scored against an in-bench slot table
// model, with random idle cycles on both sides and long result back-pressure
// ----------------------------------------------------------------------------
module priority_timeout_command_mux_top_tb;
  import ptcm_pkg::*;

  localparam int NUM_LEVELS   = 16;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 24;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  prio;
    logic [7:0]  src;
    logic [31:0] tmo;
    logic [31:0] now;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] code;
    logic       fwd;
  } reply_t;

  typedef struct packed {
    cmd_word_t cmd;
    logic      typed;
    reply_t    want;
  } dir_row_t;

  localparam reply_t ANY_REPLY = '{RC_ACCEPTED, 1'b0};

  // replies typed in where they are obvious, the rest come from the slot model
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'd0},          1'b1, '{RC_EMPTY, 1'b0}},
    '{'{OP_UNSUB, 4'd0,  8'h00, 32'd0,          32'd0},          1'b1, '{RC_NOT_FOUND, 1'b0}},
    '{'{OP_NONE,  4'd15, 8'hff, 32'hffff_ffff,  32'hffff_ffff},  1'b0, ANY_REPLY},
    '{'{OP_SUB,   4'd0,  8'h00, 32'd0,          32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_SUB,   4'd0,  8'h01, 32'd10,         32'd0},          1'b1, '{RC_PRIO_USED, 1'b0}},
    '{'{OP_SUB,   4'd0,  8'h00, 32'd0,          32'd0},          1'b1, '{RC_SRC_DUP, 1'b0}},
    '{'{OP_SUB,   4'd15, 8'hff, 32'hffff_ffff,  32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'd0},          1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd15, 8'h00, 32'd0,          32'hffff_ffff},  1'b1, '{RC_FORWARDED, 1'b1}},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'hffff_ffff},  1'b0, ANY_REPLY},
    '{'{OP_UNSUB, 4'd0,  8'hff, 32'd0,          32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_SUB,   4'd8,  8'h80, 32'd100,        32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'd99},         1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'd100},        1'b0, ANY_REPLY},
    '{'{OP_SUB,   4'd3,  8'h03, 32'd5,          32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_MSG,   4'd3,  8'h00, 32'd0,          32'd2},          1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'd6},          1'b0, ANY_REPLY},
    '{'{OP_SUB,   4'd12, 8'h0c, 32'd0,          32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_MSG,   4'd8,  8'h00, 32'd0,          32'hffff_fff0},  1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'h0000_0010},  1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd0,  8'h00, 32'd0,          32'h0000_0054},  1'b0, ANY_REPLY},
    '{'{OP_MSG,   4'd7,  8'h00, 32'd0,          32'd0},          1'b1, '{RC_EMPTY, 1'b0}},
    '{'{OP_UNSUB, 4'd0,  8'h03, 32'd0,          32'd0},          1'b1, '{RC_ACCEPTED, 1'b0}},
    '{'{OP_UNSUB, 4'd0,  8'h03, 32'd0,          32'd0},          1'b1, '{RC_NOT_FOUND, 1'b0}}
  };

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [1:0]  op;
  logic [3:0]  prio_level;
  logic [7:0]  source_id;
  logic [31:0] timeout_ticks;
  logic [31:0] now_time;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  result_code;
  logic        forward;

  // slot table model
  logic        tbl_valid [NUM_LEVELS];
  logic [7:0]  tbl_src   [NUM_LEVELS];
  logic [31:0] tbl_tmo   [NUM_LEVELS];
  logic [31:0] tbl_last  [NUM_LEVELS];

  reply_t replies_due [$];
  bit     full_speed;
  bit     hold_req;
  int     err_count;
  int     n_words;
  int     n_checked;
  int     n_fwd;
  int     n_sup;
  int     n_empty;
  int     n_reject;
  int     cycles;

  priority_timeout_command_mux_top #(
    .PRIORITY_LEVELS(NUM_LEVELS),
    .TIME_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .op(op),
    .prio_level(prio_level),
    .source_id(source_id),
    .timeout_ticks(timeout_ticks),
    .now_time(now_time),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .result_code(result_code),
    .forward(forward)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int slot_of_source(input logic [7:0] src);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (tbl_valid[i] && tbl_src[i] == src) return i;
    end
    return -1;
  endfunction

  // applies one command word to the slot table, returns 0 when no reply is due
  function automatic bit mux_decide(input cmd_word_t c, output reply_t r);
    int     hit;
    bit     outranked;
    logic [31:0] age;
    r = '{RC_ACCEPTED, 1'b0};
    outranked = 1'b0;
    case (c.op)
      OP_SUB: begin
        if (slot_of_source(c.src) >= 0) begin
          r.code = RC_SRC_DUP;
        end else if (tbl_valid[c.prio]) begin
          r.code = RC_PRIO_USED;
        end else begin
          tbl_valid[c.prio] = 1'b1;
          tbl_src[c.prio]   = c.src;
          tbl_tmo[c.prio]   = c.tmo;
          tbl_last[c.prio]  = '0;
        end
      end
      OP_UNSUB: begin
        hit = slot_of_source(c.src);
        if (hit >= 0) tbl_valid[hit] = 1'b0;
        else r.code = RC_NOT_FOUND;
      end
      OP_MSG: begin
        if (!tbl_valid[c.prio]) begin
          r.code = RC_EMPTY;
        end else begin
          tbl_last[c.prio] = c.now;
          for (int i = int'(c.prio) + 1; i < NUM_LEVELS; i++) begin
            age = c.now - tbl_last[i];
            if (tbl_valid[i] && age < tbl_tmo[i]) outranked = 1'b1;
          end
          if (outranked) begin
            r.code = RC_SUPPRESSED;
          end else begin
            r.code = RC_FORWARDED;
            r.fwd  = 1'b1;
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch on %0s: expected %0d, got %0d (reply %0d)", what, want, got, n_checked);
  endtask

  // drives one command word and queues its expected reply once the mux takes it
  task automatic send_cmd(input cmd_word_t c, input logic typed, input reply_t want);
    int     gap;
    reply_t r;
    gap = full_speed ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    op            <= c.op;
    prio_level    <= c.prio;
    source_id     <= c.src;
    timeout_ticks <= c.tmo;
    now_time      <= c.now;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    n_words++;
    if (mux_decide(c, r)) replies_due.insert(replies_due.size(), typed ? want : r);
  endtask

  // result side: random ready gaps, long hold on request
  initial begin
    int wait_left;
    int hold_left;
    reply_t want;
    wait_left = 0;
    hold_left = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (replies_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("reply word with nothing outstanding: code %0d", result_code);
        end else begin
          want = replies_due.pop_front();
          if (result_code !== want.code)
            note_mismatch("result_code", int'(want.code), int'(result_code));
          if (forward !== want.fwd)
            note_mismatch("forward", int'(want.fwd), int'(forward));
          n_checked++;
          case (want.code)
            RC_FORWARDED:  n_fwd++;
            RC_SUPPRESSED: n_sup++;
            RC_EMPTY:      n_empty++;
            RC_ACCEPTED:   ;
            default:       n_reject++;
          endcase
        end
        wait_left = full_speed ? 0 : $urandom_range(0, 3);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      res_stall <= (hold_left > 0) || (wait_left > 0);
      if (hold_left > 0) hold_left--;
      else if (wait_left > 0) wait_left--;
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d replies outstanding", cycles, replies_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    cmd_word_t   c;
    int          live [$];
    int          k;
    int          n_real;
    int          pick;
    logic [31:0] tick;
    rst           <= 1'b1;
    cmd_valid     <= 1'b0;
    op            <= OP_MSG;
    prio_level    <= '0;
    source_id     <= '0;
    timeout_ticks <= '0;
    now_time      <= '0;
    full_speed    = 1'b0;
    hold_req      = 1'b0;
    err_count     = 0;
    n_words       = 0;
    n_checked     = 0;
    n_fwd         = 0;
    n_sup         = 0;
    n_empty       = 0;
    n_reject      = 0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_src[i]   = '0;
      tbl_tmo[i]   = '0;
      tbl_last[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_cmd(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].want);

    // random traffic, mostly well-formed against the live slot table
    tick   = $urandom_range(0, 50);
    k      = 0;
    n_real = 0;
    while (n_real < RANDOM_ITEMS) begin
      full_speed = ((k / 150) % 3) == 2;
      if (k == 300 || k == 900) hold_req = 1'b1;
      if (k == 600) begin
        cmd_valid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0);
      end
      live.delete();
      for (int i = 0; i < NUM_LEVELS; i++) if (tbl_valid[i]) live.insert(live.size(), i);

      case ($urandom_range(0, 19))
        0:       tick = $urandom;
        1:       tick = $urandom_range(0, 60);
        2:       tick = 32'hffff_ffff - $urandom_range(0, 60);
        default: tick = tick + $urandom_range(0, 40);
      endcase

      c.prio = 4'($urandom_range(0, 15));
      c.src  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 23));
      case ($urandom_range(0, 9))
        0:       c.tmo = '0;
        1:       c.tmo = $urandom;
        2:       c.tmo = 32'hffff_ffff;
        default: c.tmo = $urandom_range(1, 300);
      endcase
      c.now = tick;

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        c.op = OP_NONE;
      end else if (pick < 20) begin
        c.op = OP_SUB;
      end else if (pick < 30) begin
        c.op = OP_UNSUB;
        if (live.size() != 0 && $urandom_range(0, 9) < 7)
          c.src = tbl_src[live[$urandom_range(0, live.size() - 1)]];
      end else begin
        c.op = OP_MSG;
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
          c.prio = 4'(live[$urandom_range(0, live.size() - 1)]);
      end

      send_cmd(c, 1'b0, ANY_REPLY);
      if (c.op != OP_NONE) n_real++;
      k++;
    end
    cmd_valid  <= 1'b0;
    full_speed = 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (NUM_LEVELS + 6) @(posedge clk);
    err_count += replies_due.size();

    $display("covered %0d command words and %0d replies: %0d forwarded, %0d suppressed,",
             n_words, n_checked, n_fwd, n_sup);
    $display("  %0d empty-slot drops, %0d rejected table updates, %0d errors",
             n_empty, n_reject, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
